// ----- hdl/bdpc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, register codes and reset values for the button debounce
// and press classifier; used by every module of the core

package bdpc_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebW      = 10;
  localparam int unsigned DblW      = 11;
  localparam int unsigned LongW     = 13;
  localparam int unsigned RepW      = 11;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 13;

  localparam logic [DebW-1:0]  DebounceReset = 10'd50;
  localparam logic [DblW-1:0]  DoubleReset   = 11'd400;
  localparam logic [LongW-1:0] LongReset     = 13'd700;
  localparam logic [RepW-1:0]  RepeatReset   = 11'd200;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 3'd0,
    REG_DOUBLE   = 3'd1,
    REG_LONG     = 3'd2,
    REG_REPEAT   = 3'd3,
    REG_BLOCK    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [DebW-1:0]  debounce_ms;
    logic [DblW-1:0]  double_press_ms;
    logic [LongW-1:0] long_press_ms;
    logic [RepW-1:0]  repeat_ms;
    logic             block_navigation;
  } cfg_t;

  typedef struct packed {
    logic hold;
    logic brief;
  } rocker_ev_t;

endpackage

// ----- hdl/bdpc_debounce.sv -----
`timescale 1ns / 1ps
// debounce of one raw button level with its raw change timestamp
// depends on bdpc_pkg

module bdpc_debounce (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_i,
  input  logic [bdpc_pkg::TimeW-1:0]   now_i,
  input  logic                         raw_i,
  input  logic [bdpc_pkg::DebW-1:0]    debounce_ms_i,
  output logic                         stable_o,
  output logic                         stable_next_o
);

  logic                       last_raw_q, last_raw_d;
  logic [bdpc_pkg::TimeW-1:0] change_q, change_d;
  logic                       stable_q, stable_d;
  logic [bdpc_pkg::TimeW-1:0] held_for;

  always_comb begin
    last_raw_d = raw_i;
    change_d   = (raw_i != last_raw_q) ? now_i : change_q;
    held_for   = now_i - change_d;
    stable_d   = stable_q;
    if ((raw_i != stable_q) && (held_for >= bdpc_pkg::TimeW'(debounce_ms_i))) begin
      stable_d = raw_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      change_q   <= '0;
      stable_q   <= 1'b0;
    end else if (upd_i) begin
      last_raw_q <= last_raw_d;
      change_q   <= change_d;
      stable_q   <= stable_d;
    end
  end

  assign stable_o      = stable_q;
  assign stable_next_o = stable_d;

endmodule

// ----- hdl/bdpc_rocker.sv -----
`timescale 1ns / 1ps
// long-press, repeat and short-press classification of one rocker button
// depends on bdpc_pkg

module bdpc_rocker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_i,
  input  logic [bdpc_pkg::TimeW-1:0]   now_i,
  input  logic                         held_i,
  input  logic                         was_i,
  input  logic [bdpc_pkg::LongW-1:0]   long_press_ms_i,
  input  logic [bdpc_pkg::RepW-1:0]    repeat_ms_i,
  output bdpc_pkg::rocker_ev_t         ev_o
);

  logic [bdpc_pkg::TimeW-1:0] start_q, start_d;
  logic [bdpc_pkg::TimeW-1:0] rep_q, rep_d;
  logic                       long_q, long_d;
  logic                       press;
  logic                       long_eff;
  logic [bdpc_pkg::TimeW-1:0] down_for;
  logic [bdpc_pkg::TimeW-1:0] since_rep;
  logic                       fire;

  always_comb begin
    press     = held_i && !was_i;
    start_d   = press ? now_i : start_q;
    long_eff  = press ? 1'b0 : long_q;
    down_for  = now_i - start_d;
    since_rep = now_i - rep_q;
    fire      = held_i && (down_for >= bdpc_pkg::TimeW'(long_press_ms_i)) &&
                (!long_eff || (since_rep >= bdpc_pkg::TimeW'(repeat_ms_i)));
    long_d    = fire ? 1'b1 : long_eff;
    rep_d     = fire ? now_i : rep_q;
    ev_o.hold  = fire;
    ev_o.brief = !held_i && was_i && !long_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      rep_q   <= '0;
      long_q  <= 1'b0;
    end else if (upd_i) begin
      start_q <= start_d;
      rep_q   <= rep_d;
      long_q  <= long_d;
    end
  end

endmodule

// ----- hdl/bdpc_select.sv -----
`timescale 1ns / 1ps
// select edge tracking and double-press detection
// depends on bdpc_pkg

module bdpc_select (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_i,
  input  logic [bdpc_pkg::TimeW-1:0]   now_i,
  input  logic                         sel_rise_i,
  input  logic [bdpc_pkg::DblW-1:0]    double_press_ms_i,
  input  logic                         block_navigation_i,
  output logic                         dbl_o
);

  logic [bdpc_pkg::TimeW-1:0] edge_time_q;
  logic                       edge_valid_q;
  logic [bdpc_pkg::TimeW-1:0] gap;

  always_comb begin
    gap   = now_i - edge_time_q;
    dbl_o = sel_rise_i && !block_navigation_i && edge_valid_q &&
            (gap <= bdpc_pkg::TimeW'(double_press_ms_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_time_q  <= '0;
      edge_valid_q <= 1'b0;
    end else if (upd_i && sel_rise_i) begin
      edge_time_q  <= now_i;
      edge_valid_q <= 1'b1;
    end
  end

endmodule

// ----- hdl/button_debounce_press_classifier_core.sv -----
`timescale 1ns / 1ps
// button debounce and press classifier: input register, classification pass
// and result register; depends on bdpc_pkg, bdpc_debounce, bdpc_rocker, bdpc_select
// an accepted item waits in the input register until the result register is free
// throughput: one item per cycle unless stalled, set by the single classification pass
// reset: all button state cleared, registers back to their defaults, both stages empty

module button_debounce_press_classifier_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bdpc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bdpc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bdpc_pkg::TimeW-1:0]      now_ms_i,
  input  logic                            raw_left_i,
  input  logic                            raw_select_i,
  input  logic                            raw_right_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hold_down_o,
  output logic                            hold_up_o,
  output logic                            short_down_o,
  output logic                            short_up_o,
  output logic                            select_press_o,
  output logic                            double_select_o,
  output logic                            stable_left_o,
  output logic                            stable_select_o,
  output logic                            stable_right_o,
  output logic                            buttons_changed_o
);

  bdpc_pkg::cfg_t             cfg_q;
  logic                       in_valid_q;
  logic [bdpc_pkg::TimeW-1:0] now_q;
  logic [2:0]                 raw_q;
  logic                       out_free;
  logic                       adv;
  logic [2:0]                 stab_cur;
  logic [2:0]                 stab_nxt;
  bdpc_pkg::rocker_ev_t       ev_left;
  bdpc_pkg::rocker_ev_t       ev_right;
  logic                       sel_rise;
  logic                       dbl;
  logic [9:0]                 res_d, res_q;
  logic                       out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms      <= bdpc_pkg::DebounceReset;
      cfg_q.double_press_ms  <= bdpc_pkg::DoubleReset;
      cfg_q.long_press_ms    <= bdpc_pkg::LongReset;
      cfg_q.repeat_ms        <= bdpc_pkg::RepeatReset;
      cfg_q.block_navigation <= 1'b0;
    end else if (cfg_we_i) begin
      case (bdpc_pkg::cfg_reg_e'(cfg_idx_i))
        bdpc_pkg::REG_DEBOUNCE: cfg_q.debounce_ms     <= cfg_wdata_i[bdpc_pkg::DebW-1:0];
        bdpc_pkg::REG_DOUBLE:   cfg_q.double_press_ms <= cfg_wdata_i[bdpc_pkg::DblW-1:0];
        bdpc_pkg::REG_LONG:     cfg_q.long_press_ms   <= cfg_wdata_i[bdpc_pkg::LongW-1:0];
        bdpc_pkg::REG_REPEAT:   cfg_q.repeat_ms       <= cfg_wdata_i[bdpc_pkg::RepW-1:0];
        bdpc_pkg::REG_BLOCK:    cfg_q.block_navigation <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      now_q <= now_ms_i;
      raw_q <= {raw_right_i, raw_select_i, raw_left_i};
    end
  end

  // per-button debounce, bit 0 left, bit 1 select, bit 2 right
  for (genvar b = 0; b < 3; b++) begin : g_deb
    bdpc_debounce u_deb (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .upd_i         (adv),
      .now_i         (now_q),
      .raw_i         (raw_q[b]),
      .debounce_ms_i (cfg_q.debounce_ms),
      .stable_o      (stab_cur[b]),
      .stable_next_o (stab_nxt[b])
    );
  end

  bdpc_rocker u_left (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .upd_i           (adv),
    .now_i           (now_q),
    .held_i          (stab_nxt[0]),
    .was_i           (stab_cur[0]),
    .long_press_ms_i (cfg_q.long_press_ms),
    .repeat_ms_i     (cfg_q.repeat_ms),
    .ev_o            (ev_left)
  );

  bdpc_rocker u_right (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .upd_i           (adv),
    .now_i           (now_q),
    .held_i          (stab_nxt[2]),
    .was_i           (stab_cur[2]),
    .long_press_ms_i (cfg_q.long_press_ms),
    .repeat_ms_i     (cfg_q.repeat_ms),
    .ev_o            (ev_right)
  );

  assign sel_rise = stab_nxt[1] && !stab_cur[1];

  bdpc_select u_sel (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .upd_i              (adv),
    .now_i              (now_q),
    .sel_rise_i         (sel_rise),
    .double_press_ms_i  (cfg_q.double_press_ms),
    .block_navigation_i (cfg_q.block_navigation),
    .dbl_o              (dbl)
  );

  assign res_d = {(stab_nxt != stab_cur), stab_nxt[2], stab_nxt[1], stab_nxt[0],
                  dbl, sel_rise, ev_right.brief, ev_left.brief,
                  ev_right.hold, ev_left.hold};

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hold_down_o       = res_q[0];
  assign hold_up_o         = res_q[1];
  assign short_down_o      = res_q[2];
  assign short_up_o        = res_q[3];
  assign select_press_o    = res_q[4];
  assign double_select_o   = res_q[5];
  assign stable_left_o     = res_q[6];
  assign stable_select_o   = res_q[7];
  assign stable_right_o    = res_q[8];
  assign buttons_changed_o = res_q[9];

endmodule

// ----- hdl/bdpc_checker.sv -----
`timescale 1ns / 1ps
// port-level checks on the classifier core and the bind that attaches them
// depends on bdpc_pkg and button_debounce_press_classifier_core

module bdpc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bdpc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bdpc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_o,
  input  logic [bdpc_pkg::TimeW-1:0]      now_ms_i,
  input  logic                            raw_left_i,
  input  logic                            raw_select_i,
  input  logic                            raw_right_i,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic                            hold_down_o,
  input  logic                            hold_up_o,
  input  logic                            short_down_o,
  input  logic                            short_up_o,
  input  logic                            select_press_o,
  input  logic                            double_select_o,
  input  logic                            stable_left_o,
  input  logic                            stable_select_o,
  input  logic                            stable_right_o,
  input  logic                            buttons_changed_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(stable_left_o) &&
    $stable(stable_select_o) && $stable(stable_right_o) && $stable(hold_down_o))
    else $error("result changed while stalled");

  // hold events need the button down, short events need it up
  a_rocker_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!hold_down_o || stable_left_o) && (!short_down_o || !stable_left_o) &&
    (!hold_up_o || stable_right_o) && (!short_up_o || !stable_right_o))
    else $error("rocker event disagrees with debounced level");

  // double press only on a select edge, and an edge is a level change
  a_double_on_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && double_select_o |-> select_press_o && stable_select_o)
    else $error("double select without select edge");

  a_edge_changes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (select_press_o || short_down_o || short_up_o) |-> buttons_changed_o)
    else $error("edge event without level change");

endmodule

bind button_debounce_press_classifier_core bdpc_checker u_bdpc_checker (.*);
